// ===== rtl/core/bsed_pkg.sv =====
// Shared types and constants for the backslash escape decoder.
// No dependencies; every other file in rtl/core imports this package.
package bsed_pkg;

  localparam int FifoDepth = 4;
  localparam int PtrWidth = $clog2(FifoDepth);
  localparam int CountWidth = $clog2(FifoDepth + 1);

  localparam logic [2:0] CfgAddrWidth = 3'd3;
  localparam logic CfgIdxEscapes = 1'b0;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerB = 8'h62;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChLowerV = 8'h76;
  localparam logic [7:0] ChLowerC = 8'h63;

  localparam logic [7:0] CtlNewline = 8'h0A;
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlReturn = 8'h0D;
  localparam logic [7:0] CtlBell = 8'h07;
  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlFormFeed = 8'h0C;
  localparam logic [7:0] CtlVertTab = 8'h0B;

  localparam logic [1:0] OctalLastDigit = 2'd2;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_ESC = 3'd1,
    PH_OCT = 3'd2,
    PH_DROP = 3'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic two;
  } entry_t;

endpackage

// ===== rtl/core/bsed_front.sv =====
// Front part: decodes each accepted byte, keeps the escape state and
// produces up to two result bytes per item. Depends on bsed_pkg.
module bsed_front import bsed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       enabled,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       last_of_string,
  output logic       wr_en,
  output entry_t     wr_entry
);

  phase_t phase, phase_next;
  logic [7:0] octal_value, octal_value_next;
  logic [1:0] octal_digits_seen, octal_digits_seen_next;
  logic [1:0] n;
  logic [7:0] b0, b1;
  logic is_digit;

  assign is_digit = (ch >= ChZero) && (ch <= ChSeven);

  always_comb begin
    phase_next = phase;
    octal_value_next = octal_value;
    octal_digits_seen_next = octal_digits_seen;
    n = 2'd0;
    b0 = ch;
    b1 = ch;
    if (!enabled) begin
      phase_next = PH_PLAIN;
      octal_value_next = 8'd0;
      octal_digits_seen_next = 2'd0;
      n = 2'd1;
    end else begin
      case (phase)
        PH_ESC: begin
          phase_next = PH_PLAIN;
          n = 2'd1;
          case (ch)
            ChLowerN: b0 = CtlNewline;
            ChLowerT: b0 = CtlTab;
            ChLowerR: b0 = CtlReturn;
            ChBackslash: b0 = ChBackslash;
            ChLowerA: b0 = CtlBell;
            ChLowerB: b0 = CtlBackspace;
            ChLowerF: b0 = CtlFormFeed;
            ChLowerV: b0 = CtlVertTab;
            ChZero: begin
              phase_next = PH_OCT;
              octal_value_next = 8'd0;
              octal_digits_seen_next = 2'd0;
              n = 2'd0;
            end
            ChLowerC: begin
              phase_next = PH_DROP;
              n = 2'd0;
            end
            default: begin
              b0 = ChBackslash;
              b1 = ch;
              n = 2'd2;
            end
          endcase
        end
        PH_OCT: begin
          if (is_digit) begin
            octal_value_next = {octal_value[4:0], ch[2:0]};
            octal_digits_seen_next = octal_digits_seen + 2'd1;
            if (octal_digits_seen == OctalLastDigit) begin
              b0 = octal_value_next;
              n = 2'd1;
              phase_next = PH_PLAIN;
              octal_value_next = 8'd0;
              octal_digits_seen_next = 2'd0;
            end
          end else begin
            b0 = octal_value;
            n = 2'd1;
            phase_next = PH_PLAIN;
            octal_value_next = 8'd0;
            octal_digits_seen_next = 2'd0;
            if (ch == ChBackslash && !last_of_string) begin
              phase_next = PH_ESC;
            end else begin
              b1 = ch;
              n = 2'd2;
            end
          end
        end
        PH_DROP: begin
          n = 2'd0;
        end
        default: begin
          phase_next = PH_PLAIN;
          if (ch == ChBackslash && !last_of_string) begin
            phase_next = PH_ESC;
          end else begin
            n = 2'd1;
          end
        end
      endcase
      if (last_of_string) begin
        if (phase_next == PH_OCT) begin
          if (n == 2'd0) begin
            b0 = octal_value_next;
          end else begin
            b1 = octal_value_next;
          end
          n = n + 2'd1;
        end
        phase_next = PH_PLAIN;
        octal_value_next = 8'd0;
        octal_digits_seen_next = 2'd0;
      end
    end
  end

  assign wr_en = accept && (n != 2'd0);
  assign wr_entry = '{b0: b0, b1: b1, two: (n == 2'd2)};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PLAIN;
      octal_value <= 8'd0;
      octal_digits_seen <= 2'd0;
    end else if (accept) begin
      phase <= phase_next;
      octal_value <= octal_value_next;
      octal_digits_seen <= octal_digits_seen_next;
    end
  end

endmodule

// ===== rtl/core/bsed_fifo.sv =====
// Short queue of decoded entries between the front and back parts.
// Depends on bsed_pkg for the entry type and depth.
module bsed_fifo import bsed_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_entry,
  input  logic   rd_en,
  output entry_t rd_entry,
  output logic   full,
  output logic   fifo_empty
);

  entry_t mem [FifoDepth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CountWidth-1:0] count;

  assign full = (count == CountWidth'(FifoDepth));
  assign fifo_empty = (count == '0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/bsed_back.sv =====
// Back part: delivers the bytes of each queued entry one word at a time.
// Depends on bsed_pkg for the entry type.
module bsed_back import bsed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       fifo_empty,
  input  logic       pop,
  output logic       rd_en,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic sel;
  logic take;

  assign empty = fifo_empty;
  assign take = pop && !fifo_empty;
  assign out_byte = sel ? head.b1 : head.b0;
  assign out_last = sel || !head.two;
  assign rd_en = take && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (take) begin
      sel <= !out_last;
    end
  end

endmodule

// ===== rtl/core/backslash_escape_decoder.sv =====
// Top level of the backslash escape decoder; holds the configuration register.
// Depends on bsed_pkg, bsed_front, bsed_fifo and bsed_back.
//
// A byte is taken every cycle while push is high and full is low; its decoding
// is done in the cycle it is accepted and its results enter a four-entry queue.
// Results leave one word per cycle while pop is high, so an item that yields
// two words (an unknown escape, or an octal number ended by a byte that does
// not open a new escape) needs two pops; the queue absorbs such bursts. Items
// wait in the queue until they reach its head. escapes_enabled sits at byte address 0.
module backslash_escape_decoder import bsed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch,
  input  logic        last_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic escapes_enabled;
  logic accept;
  logic wr_en;
  logic rd_en;
  logic fifo_empty;
  entry_t wr_entry;
  entry_t head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CfgIdxEscapes) ? {31'd0, escapes_enabled} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      escapes_enabled <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == CfgIdxEscapes) begin
      escapes_enabled <= pwdata[0];
    end
  end

  assign accept = push && !full;

  bsed_front u_front (
    .clk            (clk),
    .rst            (rst),
    .enabled        (escapes_enabled),
    .accept         (accept),
    .ch             (ch),
    .last_of_string (last_of_string),
    .wr_en          (wr_en),
    .wr_entry       (wr_entry)
  );

  bsed_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_entry   (wr_entry),
    .rd_en      (rd_en),
    .rd_entry   (head),
    .full       (full),
    .fifo_empty (fifo_empty)
  );

  bsed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .rd_en      (rd_en),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
